// ===== rtl/core/gpt_pkg.sv =====
package gpt_pkg;

    localparam int DEF_PIN_COUNT = 64;
    localparam int PIN_W = 6;
    localparam int CNT_W = 32;

    localparam int IN_FIELDS_W = 3 + PIN_W + 1 + 1;
    localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + 2 + 3 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        OP_CONFIGURE       = 3'd0,
        OP_READ            = 3'd1,
        OP_WRITE           = 3'd2,
        OP_INJECT          = 3'd3,
        OP_UNCONFIGURE_ALL = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK               = 2'd0,
        ERR_NOT_CONFIGURED   = 2'd1,
        ERR_WRITE_TO_INPUT   = 2'd2,
        ERR_INJECT_TO_OUTPUT = 2'd3
    } err_t;

    typedef struct packed {
        op_t              op;
        logic [PIN_W-1:0] pin;
        logic             dir_output;
        logic             level;
    } item_t;

    // Per-pin payload kept in RAM.
    typedef struct packed {
        logic is_output;
        logic level;
        logic pending_level;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   ram_we;
        entry_t wdata;
        logic   set_cfg;
        logic   set_pend;
        logic   clear_all;
        logic   inc_cfg;
        logic   inc_rd;
        logic   inc_wr;
        logic   read_level;
        err_t   error;
    } upd_t;

endpackage

// ===== rtl/core/gpt_ram.sv =====
module gpt_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/gpt_exec.sv =====
module gpt_exec (
    input  gpt_pkg::item_t  item,
    input  logic            in_range,
    input  logic            configured,
    input  logic            pend_valid,
    input  gpt_pkg::entry_t entry,
    output gpt_pkg::upd_t   upd
);
    import gpt_pkg::*;

    logic cfg;

    assign cfg = in_range && configured;

    always_comb begin
        upd            = '0;
        upd.error      = ERR_OK;
        upd.wdata      = entry;
        case (item.op)
            OP_CONFIGURE: begin
                if (in_range) begin
                    upd.ram_we          = 1'b1;
                    upd.wdata.is_output = item.dir_output;
                    upd.wdata.level     = (!item.dir_output && pend_valid) ?
                                          entry.pending_level : item.level;
                    upd.set_cfg         = 1'b1;
                    upd.inc_cfg         = 1'b1;
                end
            end
            OP_READ: begin
                if (!cfg) begin
                    upd.error = ERR_NOT_CONFIGURED;
                end else begin
                    upd.read_level = entry.level;
                    upd.inc_rd     = 1'b1;
                end
            end
            OP_WRITE: begin
                if (!cfg) begin
                    upd.error = ERR_NOT_CONFIGURED;
                end else if (!entry.is_output) begin
                    upd.error = ERR_WRITE_TO_INPUT;
                end else begin
                    upd.ram_we      = 1'b1;
                    upd.wdata.level = item.level;
                    upd.inc_wr      = 1'b1;
                end
            end
            OP_INJECT: begin
                if (in_range) begin
                    if (!cfg) begin
                        upd.ram_we              = 1'b1;
                        upd.wdata.pending_level = item.level;
                        upd.set_pend            = 1'b1;
                    end else if (entry.is_output) begin
                        upd.error = ERR_INJECT_TO_OUTPUT;
                    end else begin
                        upd.ram_we              = 1'b1;
                        upd.wdata.level         = item.level;
                        upd.wdata.pending_level = item.level;
                        upd.set_pend            = 1'b1;
                    end
                end
            end
            OP_UNCONFIGURE_ALL: begin
                upd.clear_all = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/gpio_pin_table_checked_unit.sv =====
// Channel   Direction  tdata fields (lowest bit up)
// s_        in         op[2:0], pin[8:3], dir_output[9], level[10], zero pad to 16
// m_        out        read_level[0], error[2:1], configures_done[34:3],
//                      reads_done[66:35], writes_done[98:67], zero pad to 104
//
// Accepts one request per cycle unless stalled; request and result are each registered.
// The pin RAM read is registered, so the entry written by the request ahead is forwarded.
// Reset clears the configured and pending-valid flags, the counters and all valid bits.
// A stalled result stalls the execute stage, which then drops s_tready.
module gpio_pin_table_checked_unit #(
    parameter int PIN_COUNT = gpt_pkg::DEF_PIN_COUNT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gpt_pkg::IN_TDATA_W-1:0]  s_tdata,  // op, pin, dir_output, level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gpt_pkg::OUT_TDATA_W-1:0] m_tdata   // read_level, error, counters
);
    import gpt_pkg::*;

    localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    item_t              s_item;
    logic               s_in_range;
    logic [IDX_W-1:0]   s_addr;
    logic               s_fire;

    item_t              item_reg;
    logic               st_valid_reg;
    logic               st_in_range;
    logic [IDX_W-1:0]   st_addr;
    logic               exec_fire;

    logic               fwd_hit_reg;
    entry_t             fwd_data_reg;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             entry;

    logic [PIN_COUNT-1:0] configured_reg;
    logic [PIN_COUNT-1:0] pend_valid_reg;

    upd_t               upd;

    logic [CNT_W-1:0]   cfg_cnt_reg, cfg_cnt_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]   wr_cnt_reg, wr_cnt_next;

    logic               m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    assign s_item.op         = op_t'(s_tdata[2:0]);
    assign s_item.pin        = s_tdata[3 +: PIN_W];
    assign s_item.dir_output = s_tdata[3 + PIN_W];
    assign s_item.level      = s_tdata[4 + PIN_W];

    assign s_in_range  = 32'(s_item.pin) < PIN_COUNT;
    assign s_addr      = s_in_range ? IDX_W'(s_item.pin) : '0;
    assign st_in_range = 32'(item_reg.pin) < PIN_COUNT;
    assign st_addr     = st_in_range ? IDX_W'(item_reg.pin) : '0;

    assign exec_fire = st_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !st_valid_reg || exec_fire;
    assign s_fire    = s_tvalid && s_tready;

    gpt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(PIN_COUNT)
    ) u_ram (
        .aclk (aclk),
        .we   (exec_fire && upd.ram_we),
        .waddr(st_addr),
        .wdata(upd.wdata),
        .re   (s_fire),
        .raddr(s_addr),
        .rdata(ram_rdata)
    );

    assign entry = fwd_hit_reg ? fwd_data_reg : entry_t'(ram_rdata);

    gpt_exec u_exec (
        .item      (item_reg),
        .in_range  (st_in_range),
        .configured(configured_reg[st_addr]),
        .pend_valid(pend_valid_reg[st_addr]),
        .entry     (entry),
        .upd       (upd)
    );

    assign cfg_cnt_next = cfg_cnt_reg + CNT_W'(upd.inc_cfg);
    assign rd_cnt_next  = rd_cnt_reg + CNT_W'(upd.inc_rd);
    assign wr_cnt_next  = wr_cnt_reg + CNT_W'(upd.inc_wr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            configured_reg <= '0;
            pend_valid_reg <= '0;
            cfg_cnt_reg    <= '0;
            rd_cnt_reg     <= '0;
            wr_cnt_reg     <= '0;
        end else begin
            if (s_fire) begin
                st_valid_reg <= 1'b1;
                fwd_hit_reg  <= exec_fire && upd.ram_we && (st_addr == s_addr);
            end else if (exec_fire) begin
                st_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                if (upd.clear_all) begin
                    configured_reg <= '0;
                end else if (upd.set_cfg) begin
                    configured_reg[st_addr] <= 1'b1;
                end
                if (upd.set_pend) begin
                    pend_valid_reg[st_addr] <= 1'b1;
                end
                cfg_cnt_reg <= cfg_cnt_next;
                rd_cnt_reg  <= rd_cnt_next;
                wr_cnt_reg  <= wr_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg     <= s_item;
            fwd_data_reg <= upd.wdata;
        end
        if (exec_fire) begin
            m_data_reg <= OUT_TDATA_W'({wr_cnt_next, rd_cnt_next, cfg_cnt_next,
                                        upd.error, upd.read_level});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/gpt_checker.sv =====
module gpt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [gpt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gpt_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import gpt_pkg::*;

    logic [CNT_W-1:0] cfg_last_reg, rd_last_reg, wr_last_reg;
    logic [CNT_W-1:0] cfg_now, rd_now, wr_now;
    logic             m_fire;
    logic             s_unused;

    assign cfg_now  = m_tdata[3 +: CNT_W];
    assign rd_now   = m_tdata[3 + CNT_W +: CNT_W];
    assign wr_now   = m_tdata[3 + 2 * CNT_W +: CNT_W];
    assign m_fire   = m_tvalid && m_tready;
    assign s_unused = s_tvalid ^ (^s_tdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_last_reg <= '0;
            rd_last_reg  <= '0;
            wr_last_reg  <= '0;
        end else if (m_fire) begin
            cfg_last_reg <= cfg_now;
            rd_last_reg  <= rd_now;
            wr_last_reg  <= wr_now;
        end
    end

    // A waiting result holds until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty output side never blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output empty");

    // At most one counter advances per result, by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire |-> ((cfg_now == cfg_last_reg) || (cfg_now == cfg_last_reg + 1'b1))
               && ((rd_now == rd_last_reg) || (rd_now == rd_last_reg + 1'b1))
               && ((wr_now == wr_last_reg) || (wr_now == wr_last_reg + 1'b1))
               && ((cfg_now == cfg_last_reg) + (rd_now == rd_last_reg)
                   + (wr_now == wr_last_reg) >= 2'd2))
        else $error("counters advanced inconsistently");

    // A failed request changes no counter, and a high read level means a counted read.
    assert property (@(posedge aclk) disable iff (!aresetn || s_unused === 1'bx)
        m_fire |-> ((m_tdata[2:1] == ERR_OK) || ((cfg_now == cfg_last_reg)
                   && (rd_now == rd_last_reg) && (wr_now == wr_last_reg)))
               && (!m_tdata[0] || ((m_tdata[2:1] == ERR_OK)
                   && (rd_now == rd_last_reg + 1'b1))))
        else $error("result fields disagree with counters");

endmodule

bind gpio_pin_table_checked_unit gpt_checker u_gpt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// ===== tb/gpio_pin_table_checked_unit_test.sv =====
`timescale 1ns / 100ps

module gpio_pin_table_checked_unit_test;
    import gpt_pkg::*;

    localparam int PINS = DEF_PIN_COUNT;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam int LONG_HOLD = 240;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_REQUESTS = 400;

    typedef struct packed {
        logic [CNT_W-1:0] writes_done;
        logic [CNT_W-1:0] reads_done;
        logic [CNT_W-1:0] configures_done;
        err_t             error;
        logic             read_level;
    } reply_t;

    class pin_table_scoreboard;
        bit configured [PINS];
        bit is_output [PINS];
        bit level [PINS];
        bit pend_valid [PINS];
        bit pend_level [PINS];
        logic [CNT_W-1:0] configure_total = '0;
        logic [CNT_W-1:0] read_total = '0;
        logic [CNT_W-1:0] write_total = '0;
        reply_t predicted_replies [$];
        int fault_count = 0;
        int requests_seen = 0;
        int replies_checked = 0;
        int error_hits [4];

        function reply_t pin_table_reply(logic [2:0] op, logic [PIN_W-1:0] pin,
                                         logic dir_out, logic lvl);
            reply_t r;
            bit present;
            bit live;
            int idx;
            r = '0;
            present = pin < PINS;
            idx = present ? int'(pin) : 0;
            live = present && configured[idx];
            case (op)
                OP_CONFIGURE: begin
                    if (present) begin
                        if (!dir_out && pend_valid[idx]) begin
                            lvl = pend_level[idx];
                        end
                        configured[idx] = 1'b1;
                        is_output[idx] = dir_out;
                        level[idx] = lvl;
                        configure_total++;
                    end
                end
                OP_READ: begin
                    if (!live) begin
                        r.error = ERR_NOT_CONFIGURED;
                    end else begin
                        r.read_level = level[idx];
                        read_total++;
                    end
                end
                OP_WRITE: begin
                    if (!live) begin
                        r.error = ERR_NOT_CONFIGURED;
                    end else if (!is_output[idx]) begin
                        r.error = ERR_WRITE_TO_INPUT;
                    end else begin
                        level[idx] = lvl;
                        write_total++;
                    end
                end
                OP_INJECT: begin
                    if (present) begin
                        if (!live) begin
                            pend_valid[idx] = 1'b1;
                            pend_level[idx] = lvl;
                        end else if (is_output[idx]) begin
                            r.error = ERR_INJECT_TO_OUTPUT;
                        end else begin
                            level[idx] = lvl;
                            pend_valid[idx] = 1'b1;
                            pend_level[idx] = lvl;
                        end
                    end
                end
                OP_UNCONFIGURE_ALL: begin
                    foreach (configured[i]) begin
                        configured[i] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            r.configures_done = configure_total;
            r.reads_done = read_total;
            r.writes_done = write_total;
            return r;
        endfunction

        function void note_request(logic [2:0] op, logic [PIN_W-1:0] pin,
                                   logic dir_out, logic lvl);
            reply_t r;
            r = pin_table_reply(op, pin, dir_out, lvl);
            predicted_replies = {predicted_replies, r};
            error_hits[r.error]++;
            requests_seen++;
        endfunction

        function void note_fault(string msg);
            fault_count++;
            if (fault_count <= 10) begin
                $display("[%0t] %s", $realtime, msg);
            end
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got, int idx);
            if (want !== got) begin
                note_fault($sformatf("result %0d %s: expected %0h, actual %0h",
                                     idx, name, want, got));
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            reply_t got;
            reply_t want;
            got = word[OUT_FIELDS_W-1:0];
            if (predicted_replies.size() == 0) begin
                note_fault($sformatf("unexpected result %0h", got));
                return;
            end
            want = predicted_replies.pop_front();
            compare_field("read_level", CNT_W'(want.read_level), CNT_W'(got.read_level),
                          replies_checked);
            compare_field("error", CNT_W'(want.error), CNT_W'(got.error), replies_checked);
            compare_field("configures_done", want.configures_done, got.configures_done,
                          replies_checked);
            compare_field("reads_done", want.reads_done, got.reads_done, replies_checked);
            compare_field("writes_done", want.writes_done, got.writes_done, replies_checked);
            replies_checked++;
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    pin_table_scoreboard sb;
    bit sender_eager;
    bit receiver_eager;
    bit long_hold_due;

    gpio_pin_table_checked_unit #(
        .PIN_COUNT(PINS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #6000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_request(input logic [2:0] op, input logic [PIN_W-1:0] pin,
                                input logic dir_out, input logic lvl);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'({lvl, dir_out, pin, op});
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, pin, dir_out, lvl);
    endtask

    // Most requests land on a few low pins so that configured pins are hit often.
    task automatic random_requests(input int count);
        int roll;
        logic [2:0] op;
        logic [PIN_W-1:0] pin;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                op = OP_CONFIGURE;
            end else if (roll < 50) begin
                op = OP_READ;
            end else if (roll < 70) begin
                op = OP_WRITE;
            end else if (roll < 92) begin
                op = OP_INJECT;
            end else if (roll < 94) begin
                op = OP_UNCONFIGURE_ALL;
            end else begin
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end
            if ($urandom_range(0, 2) == 0) begin
                pin = PIN_W'($urandom_range(0, PINS - 1));
            end else begin
                pin = PIN_W'($urandom_range(0, 7));
            end
            send_request(op, pin, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = receiver_eager ? 0 : $urandom_range(0, 11);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        sb = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(OP_READ, 6'd0, 1'b0, 1'b1);
        send_request(OP_WRITE, 6'd63, 1'b1, 1'b1);
        send_request(OP_INJECT, 6'd5, 1'b0, 1'b1);
        send_request(OP_CONFIGURE, 6'd5, 1'b0, 1'b0);
        send_request(OP_READ, 6'd5, 1'b0, 1'b0);
        send_request(OP_WRITE, 6'd5, 1'b0, 1'b0);
        send_request(OP_INJECT, 6'd5, 1'b0, 1'b0);
        send_request(OP_READ, 6'd5, 1'b1, 1'b1);
        send_request(OP_CONFIGURE, 6'd63, 1'b1, 1'b1);
        send_request(OP_READ, 6'd63, 1'b0, 1'b0);
        send_request(OP_WRITE, 6'd63, 1'b0, 1'b0);
        send_request(OP_READ, 6'd63, 1'b0, 1'b0);
        send_request(OP_INJECT, 6'd63, 1'b0, 1'b1);
        send_request(OP_CONFIGURE, 6'd63, 1'b1, 1'b1);
        send_request(OP_CONFIGURE, 6'd0, 1'b0, 1'b1);
        send_request(OP_READ, 6'd0, 1'b0, 1'b0);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
            send_request(3'(c), 6'd42, 1'b1, 1'b1);
        end
        send_request(OP_UNCONFIGURE_ALL, 6'd42, 1'b1, 1'b1);
        send_request(OP_READ, 6'd63, 1'b0, 1'b0);
        send_request(OP_INJECT, 6'd63, 1'b0, 1'b1);
        send_request(OP_CONFIGURE, 6'd63, 1'b1, 1'b0);
        send_request(OP_READ, 6'd63, 1'b0, 1'b0);
        send_request(OP_CONFIGURE, 6'd5, 1'b0, 1'b1);
        send_request(OP_READ, 6'd5, 1'b0, 1'b0);

        random_requests(PHASE_REQUESTS);
        sender_eager = 1'b1;
        receiver_eager = 1'b1;
        random_requests(PHASE_REQUESTS);
        receiver_eager = 1'b0;
        long_hold_due = 1'b1;
        random_requests(PHASE_REQUESTS);
        sender_eager = 1'b0;
        receiver_eager = 1'b1;
        random_requests(PHASE_REQUESTS);
        s_tvalid <= 1'b0;

        while (sb.predicted_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests over gap, back-to-back and long-stall phases;",
                 sb.requests_seen);
        $display("%0d results checked, errors ok/unconf/wr-in/inj-out: %0d/%0d/%0d/%0d.",
                 sb.replies_checked,
                 sb.error_hits[ERR_OK], sb.error_hits[ERR_NOT_CONFIGURED],
                 sb.error_hits[ERR_WRITE_TO_INPUT], sb.error_hits[ERR_INJECT_TO_OUTPUT]);
        if (sb.fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches in total.", sb.fault_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gpt_pkg.sv
rtl/core/gpt_ram.sv
rtl/core/gpt_exec.sv
rtl/core/gpio_pin_table_checked_unit.sv
rtl/core/gpt_checker.sv
tb/gpio_pin_table_checked_unit_test.sv
